[hw/rtl/seu_pkg.sv]
// Shared types and constants for the SQL-escaping UTF-8 encoder.
// Used by the classifier, the item queue, the byte serializer and the top level.
`default_nettype none

package seu_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned MaxBytes  = 4;
  localparam int unsigned IdxWidth  = $clog2(MaxBytes);

  // Code points that are replaced by a backslash escape.
  localparam logic [CpWidth-1:0] CpNul   = 21'h00000;
  localparam logic [CpWidth-1:0] CpLf    = 21'h0000A;
  localparam logic [CpWidth-1:0] CpCr    = 21'h0000D;
  localparam logic [CpWidth-1:0] CpBslash = 21'h0005C;
  localparam logic [CpWidth-1:0] CpApos  = 21'h00027;
  localparam logic [CpWidth-1:0] CpQuote = 21'h00022;
  localparam logic [CpWidth-1:0] CpSub   = 21'h0001A;

  // Bytes that appear in escape sequences.
  localparam logic [ByteWidth-1:0] ChBslash = 8'h5C;
  localparam logic [ByteWidth-1:0] ChX      = 8'h78;
  localparam logic [ByteWidth-1:0] ChZero   = 8'h30;
  localparam logic [ByteWidth-1:0] ChOne    = 8'h31;
  localparam logic [ByteWidth-1:0] ChA      = 8'h61;
  localparam logic [ByteWidth-1:0] ChN      = 8'h6E;
  localparam logic [ByteWidth-1:0] ChR      = 8'h72;
  localparam logic [ByteWidth-1:0] ChApos   = 8'h27;
  localparam logic [ByteWidth-1:0] ChQuote  = 8'h22;

  // One classified item: its bytes in emission order and the index of the last one.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
    logic [IdxWidth-1:0]                last_idx;
  } enc_t;

endpackage

`default_nettype wire

[hw/rtl/seu_front.sv]
// Front end: accepts code points and classifies each into its escaped UTF-8 bytes.
// Depends on seu_pkg; feeds seu_queue.
`default_nettype none

module seu_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [seu_pkg::CpWidth-1:0]    in_code_point,
  input  wire logic                           q_full,
  output logic                                q_push,
  output seu_pkg::enc_t                       q_data
);

  logic [seu_pkg::CpWidth-1:0] cp;

  assign cp       = in_code_point;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data = '0;
    unique case (cp)
      seu_pkg::CpNul: begin
        q_data.bytes    = {seu_pkg::ChZero, seu_pkg::ChZero, seu_pkg::ChX, seu_pkg::ChBslash};
        q_data.last_idx = 2'd3;
      end
      seu_pkg::CpSub: begin
        q_data.bytes    = {seu_pkg::ChA, seu_pkg::ChOne, seu_pkg::ChX, seu_pkg::ChBslash};
        q_data.last_idx = 2'd3;
      end
      seu_pkg::CpLf: begin
        q_data.bytes[0] = seu_pkg::ChBslash;
        q_data.bytes[1] = seu_pkg::ChN;
        q_data.last_idx = 2'd1;
      end
      seu_pkg::CpCr: begin
        q_data.bytes[0] = seu_pkg::ChBslash;
        q_data.bytes[1] = seu_pkg::ChR;
        q_data.last_idx = 2'd1;
      end
      seu_pkg::CpBslash: begin
        q_data.bytes[0] = seu_pkg::ChBslash;
        q_data.bytes[1] = seu_pkg::ChBslash;
        q_data.last_idx = 2'd1;
      end
      seu_pkg::CpApos: begin
        q_data.bytes[0] = seu_pkg::ChBslash;
        q_data.bytes[1] = seu_pkg::ChApos;
        q_data.last_idx = 2'd1;
      end
      seu_pkg::CpQuote: begin
        q_data.bytes[0] = seu_pkg::ChBslash;
        q_data.bytes[1] = seu_pkg::ChQuote;
        q_data.last_idx = 2'd1;
      end
      default: begin
        // Plain UTF-8: the length follows from the highest set bit group.
        if (cp[20:16] != 5'd0) begin
          q_data.bytes[0] = {5'b11110, cp[20:18]};
          q_data.bytes[1] = {2'b10, cp[17:12]};
          q_data.bytes[2] = {2'b10, cp[11:6]};
          q_data.bytes[3] = {2'b10, cp[5:0]};
          q_data.last_idx = 2'd3;
        end else if (cp[15:11] != 5'd0) begin
          q_data.bytes[0] = {4'b1110, cp[15:12]};
          q_data.bytes[1] = {2'b10, cp[11:6]};
          q_data.bytes[2] = {2'b10, cp[5:0]};
          q_data.last_idx = 2'd2;
        end else if (cp[10:7] != 4'd0) begin
          q_data.bytes[0] = {3'b110, cp[10:6]};
          q_data.bytes[1] = {2'b10, cp[5:0]};
          q_data.last_idx = 2'd1;
        end else begin
          q_data.bytes[0] = {1'b0, cp[6:0]};
          q_data.last_idx = 2'd0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/seu_queue.sv]
// Two-entry queue of classified items between the front end and the serializer.
// Depends on seu_pkg for the item type.
`default_nettype none

module seu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire seu_pkg::enc_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output seu_pkg::enc_t      head
);

  seu_pkg::enc_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/seu_back.sv]
// Back end: walks the queued item byte by byte into the output register.
// Depends on seu_pkg; pops seu_queue as the last byte of an item is loaded.
`default_nettype none

module seu_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  wire seu_pkg::enc_t                 q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [seu_pkg::ByteWidth-1:0]      out_byte,
  output logic                               out_last_byte
);

  logic                            out_valid_r, out_valid_nxt;
  logic [seu_pkg::ByteWidth-1:0]   out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [seu_pkg::IdxWidth-1:0]    idx_r, idx_nxt;
  logic                            load;
  logic                            is_last;

  // The output register takes a new byte whenever it is empty or being drained.
  assign load    = (!out_valid_r || out_ready) && q_not_empty;
  assign is_last = (idx_r == q_head.last_idx);
  assign q_pop   = load && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = q_head.bytes[idx_r];
      out_last_nxt  = is_last;
      idx_nxt       = is_last ? '0 : idx_r + seu_pkg::IdxWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/sql_escaping_utf8_encoder.sv]
// Top level of the SQL-escaping UTF-8 encoder.
// Instantiates seu_front, seu_queue and seu_back; types from seu_pkg.
`default_nettype none

// Each accepted code point comes out as 1 to 4 bytes, one per cycle while out_ready
// is high, with out_last_byte set on the final one. Single quote, double quote,
// backslash, newline, carriage return, NUL and SUB are emitted as backslash escapes;
// everything else is plain UTF-8 over all 21 input bits, with no check for surrogates
// or values above the Unicode range. The single byte-wide output register sets the
// byte rate. Each item is written into a queue entry and then passes byte by byte
// through the output register; a two-entry queue lets new items be taken while
// earlier ones are still being emitted.
module sql_escaping_utf8_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [seu_pkg::CpWidth-1:0]   in_code_point,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [seu_pkg::ByteWidth-1:0]      out_byte,
  output logic                               out_last_byte
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  seu_pkg::enc_t q_in;
  seu_pkg::enc_t q_head;

  seu_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_point (in_code_point),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  seu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  seu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire
